// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the stripper RTL files.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define CWS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define CWS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define CWS_ASSERT_IMP(lbl, ante, cons)
`define CWS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/cws_pkg.sv =====
// Package for the comment and whitespace stripper: scan modes, result kinds,
// character constants and the result pack handed from scanner to output stage.
// No dependencies.
package cws_pkg;

	localparam int unsigned MAX_RESULTS = 3;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_SLASH  = 3'd1,
		MODE_LINE   = 3'd2,
		MODE_BLOCK  = 3'd3,
		MODE_BSTAR  = 3'd4,
		MODE_STRING = 3'd5,
		MODE_ESC    = 3'd6,
		MODE_FAILED = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_GOOD   = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
	} result_t;

	typedef struct packed {
		logic [1:0]                      count;
		result_t [MAX_RESULTS-1:0]       item;
	} pack_t;

	typedef struct packed {
		logic  valid;
		pack_t pack;
	} handoff_t;

endpackage

// ===== hw/rtl/cws_scan.sv =====
// Scanner stage: input register, scan mode register and the per-byte decode
// that produces up to three results. Depends on cws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cws_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_final,
	input  logic              pack_free,
	output cws_pkg::handoff_t hand
);
	import cws_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	mode_t      mode_q;
	logic       qdbl_q;

	logic       advance;
	mode_t      mode_d;
	logic       qdbl_d;
	logic       emit_slash;
	logic       emit_byte;
	logic       do_normal;
	logic       fin_slash;
	logic       bad;
	logic [7:0] quote;
	pack_t      pack_d;

	assign advance  = valid_s1 && pack_free;
	assign in_ready = !valid_s1 || pack_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			final_s1 <= in_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			qdbl_q <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_d;
			qdbl_q <= qdbl_d;
		end
	end

	always_comb begin
		quote      = qdbl_q ? CH_DQUOTE : CH_SQUOTE;
		mode_d     = mode_q;
		qdbl_d     = qdbl_q;
		emit_slash = 1'b0;
		emit_byte  = 1'b0;
		do_normal  = 1'b0;

		unique case (mode_q)
			MODE_NORMAL: do_normal = 1'b1;
			MODE_SLASH: begin
				if (byte_s1 == CH_SLASH) begin
					mode_d = MODE_LINE;
				end else if (byte_s1 == CH_STAR) begin
					mode_d = MODE_BLOCK;
				end else begin
					emit_slash = 1'b1;
					do_normal  = 1'b1;
				end
			end
			MODE_LINE: begin
				if (byte_s1 == CH_LF) mode_d = MODE_NORMAL;
			end
			MODE_BLOCK: begin
				if (byte_s1 == CH_STAR) mode_d = MODE_BSTAR;
			end
			MODE_BSTAR: begin
				if (byte_s1 == CH_SLASH) begin
					mode_d = MODE_NORMAL;
				end else if (byte_s1 != CH_STAR) begin
					mode_d = MODE_BLOCK;
				end
			end
			MODE_STRING: begin
				if (byte_s1 == CH_LF || byte_s1 == CH_CR) begin
					mode_d = MODE_FAILED;
				end else begin
					emit_byte = 1'b1;
					if (byte_s1 == CH_BSLASH) begin
						mode_d = MODE_ESC;
					end else if (byte_s1 == quote) begin
						mode_d = MODE_NORMAL;
					end
				end
			end
			MODE_ESC: begin
				emit_byte = 1'b1;
				mode_d    = MODE_STRING;
			end
			MODE_FAILED: begin
				mode_d = MODE_FAILED;
			end
		endcase

		// Plain text handling, also reached after a held slash that opened nothing.
		if (do_normal) begin
			priority if (byte_s1 == CH_SQUOTE || byte_s1 == CH_DQUOTE) begin
				qdbl_d    = (byte_s1 == CH_DQUOTE);
				emit_byte = 1'b1;
				mode_d    = MODE_STRING;
			end else if (byte_s1 == CH_SLASH) begin
				mode_d = MODE_SLASH;
			end else if (byte_s1 == CH_SPACE || byte_s1 == CH_TAB ||
			             byte_s1 == CH_LF || byte_s1 == CH_CR) begin
				mode_d = MODE_NORMAL;
			end else begin
				emit_byte = 1'b1;
				mode_d    = MODE_NORMAL;
			end
		end

		// A slash still held at the end of the source is flushed as text.
		fin_slash = final_s1 && (mode_d == MODE_SLASH);
		bad = (mode_d == MODE_BLOCK) || (mode_d == MODE_BSTAR) ||
		      (mode_d == MODE_STRING) || (mode_d == MODE_ESC) ||
		      (mode_d == MODE_FAILED);
		if (final_s1) begin
			mode_d = MODE_NORMAL;
			qdbl_d = 1'b0;
		end

		pack_d = '0;
		if (emit_slash) begin
			pack_d.item[pack_d.count] = '{data: CH_SLASH, kind: KIND_DATA};
			pack_d.count = pack_d.count + 2'd1;
		end
		if (emit_byte || fin_slash) begin
			pack_d.item[pack_d.count] = '{data: (emit_byte ? byte_s1 : CH_SLASH),
			                              kind: KIND_DATA};
			pack_d.count = pack_d.count + 2'd1;
		end
		if (final_s1) begin
			pack_d.item[pack_d.count] = '{data: 8'h00,
			                              kind: (bad ? KIND_REJECT : KIND_GOOD)};
			pack_d.count = pack_d.count + 2'd1;
		end
	end

	assign hand.valid = valid_s1;
	assign hand.pack  = pack_d;

	`CWS_ASSERT_NXT(a_final_resets_mode, advance && final_s1, mode_q == MODE_NORMAL && !qdbl_q)
	`CWS_ASSERT_IMP(a_two_without_end, valid_s1 && !final_s1, pack_d.count != 2'd3)

endmodule

// ===== hw/rtl/cws_drain.sv =====
// Output stage: holds the result pack of one byte and hands its results out
// one per cycle on the result channel while out_ready is high. Depends on cws_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cws_drain (
	input  logic              clk,
	input  logic              arst_n,
	input  cws_pkg::handoff_t hand,
	output logic              pack_free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic [1:0]        out_kind,
	output logic              out_last
);
	import cws_pkg::*;

	logic [1:0]                count_q;
	result_t [MAX_RESULTS-1:0] item_q;
	logic                      take;
	logic                      load;

	assign out_valid = (count_q != 2'd0);
	assign take      = out_valid && out_ready;
	assign pack_free = (count_q == 2'd0) || (count_q == 2'd1 && out_ready);
	assign load      = hand.valid && pack_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (load) begin
			count_q <= hand.pack.count;
		end else if (take) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= hand.pack.item;
		end else if (take) begin
			item_q[0] <= item_q[1];
			item_q[1] <= item_q[2];
		end
	end

	assign out_byte = item_q[0].data;
	assign out_kind = item_q[0].kind;
	assign out_last = (count_q == 2'd1);

	`CWS_ASSERT_IMP(a_report_is_last, out_valid && item_q[0].kind != KIND_DATA, count_q == 2'd1)
	`CWS_ASSERT_NXT(a_count_grows_on_load, !load, count_q <= $past(count_q))

endmodule

// ===== hw/rtl/comment_whitespace_stripper.sv =====
// Top level of the comment and whitespace stripper.
// Depends on cws_pkg, cws_scan, cws_drain and assert_macros.svh.
//
// Usage: source text enters on the s_axis channel one byte per item, with
// s_axis_tlast high on the last byte of each source. Compacted bytes leave on
// the m_axis channel; m_axis_tuser gives the kind of each result item (data,
// source ended well, source rejected) and m_axis_tlast marks the last result
// caused by one input byte. Comments, spaces, tabs, CR and LF outside quoted
// strings are dropped; quoted text passes unchanged. After a rejected source
// the consumer discards the bytes it already received from that source.
//
// A byte accepted into the input register is decoded from it, and its results are
// loaded into the output register once it is free, from where they are offered.
// Throughput: one byte per cycle while each byte gives at most one result and
// m_axis_tready is high; a byte with more results holds the output register
// until all are taken, and the next byte's results are loaded in the cycle
// its last result is taken.
// Reset clears the input and output registers and returns the scanner to
// plain text mode. When the receiver stalls, the output register holds its
// result and the input register fills, after which s_axis_tready falls.
module comment_whitespace_stripper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] text_byte
	input  logic       s_axis_tlast,  // final_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic [1:0] m_axis_tuser,  // [1:0] result_kind
	output logic       m_axis_tlast   // run_end
);
	import cws_pkg::*;

	handoff_t hand;
	logic     pack_free;

	// Decode stage: input register plus scan mode state.
	cws_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_final  (s_axis_tlast),
		.pack_free (pack_free),
		.hand      (hand)
	);

	// Result stage: holds up to three results and serializes them.
	cws_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.hand      (hand),
		.pack_free (pack_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== sim/cws_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the comment and whitespace stripper: watches both stream channels,
// predicts the results of every accepted byte and compares them in order. Depends on cws_pkg.
module cws_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic       s_axis_tlast,
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,
	input  logic [1:0] m_axis_tuser,
	input  logic       m_axis_tlast,
	output int         fail_count,
	output int         outstanding
);
	import cws_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       run_end;
	} strip_out_t;

	strip_out_t strip_q[$];
	strip_out_t step_q[$];
	strip_out_t want;
	mode_t      scan_mode;
	logic       quote_dq;
	int         errors = 0;

	assign fail_count = errors;

	task automatic emit(input logic [7:0] b, input kind_t k);
		strip_out_t r;
		r.data    = b;
		r.kind    = k;
		r.run_end = 1'b0;
		step_q = {step_q, r};
	endtask

	// Handling of a byte seen in plain text, also used after a held slash.
	task automatic plain_text(input logic [7:0] b);
		if (b == CH_SQUOTE || b == CH_DQUOTE) begin
			quote_dq = (b == CH_DQUOTE);
			emit(b, KIND_DATA);
			scan_mode = MODE_STRING;
		end else if (b == CH_SLASH) begin
			scan_mode = MODE_SLASH;
		end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
			scan_mode = MODE_NORMAL;
		end else begin
			emit(b, KIND_DATA);
			scan_mode = MODE_NORMAL;
		end
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic fin);
		logic [7:0] close_ch;
		logic       bad;
		strip_out_t r;
		close_ch = quote_dq ? CH_DQUOTE : CH_SQUOTE;
		step_q.delete();
		case (scan_mode)
			MODE_NORMAL: plain_text(b);
			MODE_SLASH: begin
				if (b == CH_SLASH)
					scan_mode = MODE_LINE;
				else if (b == CH_STAR)
					scan_mode = MODE_BLOCK;
				else begin
					emit(CH_SLASH, KIND_DATA);
					plain_text(b);
				end
			end
			MODE_LINE: begin
				if (b == CH_LF)
					scan_mode = MODE_NORMAL;
			end
			MODE_BLOCK: begin
				if (b == CH_STAR)
					scan_mode = MODE_BSTAR;
			end
			MODE_BSTAR: begin
				if (b == CH_SLASH)
					scan_mode = MODE_NORMAL;
				else if (b != CH_STAR)
					scan_mode = MODE_BLOCK;
			end
			MODE_STRING: begin
				if (b == CH_LF || b == CH_CR) begin
					scan_mode = MODE_FAILED;
				end else begin
					emit(b, KIND_DATA);
					if (b == CH_BSLASH)
						scan_mode = MODE_ESC;
					else if (b == close_ch)
						scan_mode = MODE_NORMAL;
				end
			end
			MODE_ESC: begin
				emit(b, KIND_DATA);
				scan_mode = MODE_STRING;
			end
			default: ;
		endcase

		// The last byte flushes a held slash and reports how the source ended.
		if (fin) begin
			if (scan_mode == MODE_SLASH) begin
				emit(CH_SLASH, KIND_DATA);
				scan_mode = MODE_NORMAL;
			end
			bad = (scan_mode == MODE_BLOCK || scan_mode == MODE_BSTAR ||
				scan_mode == MODE_STRING || scan_mode == MODE_ESC ||
				scan_mode == MODE_FAILED);
			emit(8'h00, bad ? KIND_REJECT : KIND_GOOD);
			scan_mode = MODE_NORMAL;
			quote_dq  = 1'b0;
		end

		if (step_q.size() > 0) begin
			r = step_q[step_q.size() - 1];
			r.run_end = 1'b1;
			step_q[step_q.size() - 1] = r;
		end
		strip_q = {strip_q, step_q};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode = MODE_NORMAL;
			quote_dq  = 1'b0;
			strip_q.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				scan_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (strip_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: got data %h kind %0d last %b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					want = strip_q.pop_front();
					if (m_axis_tdata !== want.data || m_axis_tuser !== want.kind ||
						m_axis_tlast !== want.run_end) begin
						errors++;
						$display("%0t: expected data %h kind %0d last %b, got %h %0d %b",
							$time, want.data, want.kind, want.run_end,
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
			end
		end
		outstanding <= strip_q.size();
	end

endmodule

// ===== sim/tb_comment_whitespace_stripper.sv =====
`timescale 1ns / 100ps
// Testbench top for the comment and whitespace stripper: drives source text with random
// gaps and receiver stalls, and gives the verdict. Depends on cws_pkg and cws_checker.
module tb_comment_whitespace_stripper;
	import cws_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;
	int         fail_count;
	int         outstanding;

	// Bytes of the source being sent; the last one goes out with tlast.
	logic [7:0] src_q[$];
	int         bytes_sent = 0;
	int         results_taken = 0;
	bit         send_steady = 0;
	bit         take_steady = 0;

	comment_whitespace_stripper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	cws_checker watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The slowest correct run is well under a millisecond; this is a hang guard.
	initial begin
		#5_000_000;
		$display("comment_whitespace_stripper test failed");
		$finish;
	end

	// A random byte that differs from the four given characters.
	function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == a || v == b || v == c || v == d);
		return v;
	endfunction

	// Appends one byte to the source being built.
	task automatic add_byte(input logic [7:0] b);
		src_q = {src_q, b};
	endtask

	// Offers one byte. The valid stays high across back-to-back bytes; it is lowered
	// only when a gap is drawn, so it never gets two assignments in one step.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_source();
		send_steady = ($urandom_range(0, 3) == 0);
		foreach (src_q[i])
			send_byte(src_q[i], i == src_q.size() - 1);
	endtask

	// Stops offering and waits until every predicted result has been taken. The
	// count is registered behind the checker's queue, hence the wait before the first check.
	task automatic drain_pause();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Builds a source from mostly well-formed tokens with random content, and
	// sometimes breaks it by cutting it short or by a raw line break in a string.
	task automatic make_source();
		int         ntok;
		int         k;
		logic [7:0] q;
		src_q.delete();
		ntok = $urandom_range(1, 6);
		repeat (ntok) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat ($urandom_range(1, 3))
						add_byte(any_but(CH_SLASH, CH_SQUOTE, CH_DQUOTE, CH_SLASH));
				end
				2: begin
					case ($urandom_range(0, 3))
						0: add_byte(CH_SPACE);
						1: add_byte(CH_TAB);
						2: add_byte(CH_LF);
						default: add_byte(CH_CR);
					endcase
				end
				3: begin
					add_byte(CH_SLASH);
					add_byte(CH_SLASH);
					repeat ($urandom_range(0, 5))
						add_byte(any_but(CH_LF, CH_LF, CH_LF, CH_LF));
					add_byte(CH_LF);
				end
				4: begin
					add_byte(CH_SLASH);
					add_byte(CH_STAR);
					repeat ($urandom_range(0, 5)) begin
						case ($urandom_range(0, 2))
							0: add_byte(CH_STAR);
							1: add_byte(CH_SLASH);
							default: add_byte(8'($urandom_range(0, 255)));
						endcase
					end
					add_byte(CH_STAR);
					add_byte(CH_SLASH);
				end
				5, 6: begin
					q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
					add_byte(q);
					k = $urandom_range(0, 6);
					repeat (k) begin
						if ($urandom_range(0, 3) == 0) begin
							// An escape lets any byte through, line breaks included.
							add_byte(CH_BSLASH);
							add_byte(8'($urandom_range(0, 255)));
						end else begin
							add_byte(any_but(CH_LF, CH_CR, CH_BSLASH, q));
						end
					end
					add_byte(q);
				end
				7: begin
					add_byte(CH_SLASH);
					add_byte(any_but(CH_SLASH, CH_STAR, CH_SLASH, CH_STAR));
				end
				default: add_byte(8'($urandom_range(0, 255)));
			endcase
		end
		case ($urandom_range(0, 7))
			0: begin
				k = $urandom_range(1, src_q.size());
				while (src_q.size() > k)
					void'(src_q.pop_back());
			end
			1: begin
				add_byte(CH_DQUOTE);
				add_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
				add_byte(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endtask

	// Sender and verdict.
	initial begin
		int nsrc;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		s_axis_tlast  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lone slash before a plain byte, the zero byte, and a slash as the last byte.
		src_q = '{CH_SLASH, 8'h00, CH_SLASH};
		send_source();
		// Slash-star-slash does not close the block comment; the following star-slash does.
		src_q = '{CH_SLASH, CH_STAR, CH_SLASH, CH_STAR, CH_SLASH};
		send_source();
		// Escaped line feed in a string passes; the string is never closed.
		src_q = '{CH_DQUOTE, CH_BSLASH, CH_LF, CH_SQUOTE};
		send_source();
		// Raw CR in a string fails the source and silences the rest.
		src_q = '{CH_SQUOTE, CH_CR, "x"};
		send_source();
		// Unterminated block comment, ending on the all-ones byte.
		src_q = '{CH_SLASH, CH_STAR, 8'hFF};
		send_source();
		// Line comment, dropped whitespace, and an unterminated line comment at the end.
		src_q = '{CH_SLASH, CH_SLASH, CH_LF, CH_CR, CH_SPACE, CH_SLASH, CH_SLASH};
		send_source();

		nsrc = 0;
		while (bytes_sent < 420) begin
			if (nsrc == 12)
				drain_pause();
			make_source();
			send_source();
			nsrc++;
		end

		drain_pause();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("comment_whitespace_stripper test passed");
		else
			$display("comment_whitespace_stripper test failed");
		$finish;
	end

	// Receiver: a random stall before each result, stretches with none, and one long
	// hold-off while the sender keeps offering, so that the block backs up.
	initial begin
		int gap;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (results_taken == 60) begin
				m_axis_tready <= 1'b0;
				repeat (150) @(posedge clk);
			end
			if (results_taken % 40 == 0)
				take_steady = ($urandom_range(0, 2) == 0);
			gap = take_steady ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			results_taken++;
		end
	end

endmodule
